[src/gaussian_noise_generator_assert.svh]
// ----------------------------------------------------------------------------
// gaussian noise generator assertion macros
// shared property forms for the checker, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH
`define GAUSSIAN_NOISE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GNG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GNG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/gng_pkg.sv]
// ----------------------------------------------------------------------------
// gng_pkg
// widths, constants, types and sequencer states of the gaussian generator
// ----------------------------------------------------------------------------
`default_nettype none

package gng_pkg;

	localparam int UNIFORM_WIDTH = 16;
	localparam int FRAC_BITS     = UNIFORM_WIDTH - 1;
	// squares and radius, r <= 2^(2F)
	localparam int SQ_WIDTH      = 2 * UNIFORM_WIDTH - 1;
	localparam int SHIFT_WIDTH   = $clog2(SQ_WIDTH);
	localparam int L_WIDTH       = 40;
	localparam int Q_WIDTH       = 33;
	localparam int ROOT_IN_WIDTH = L_WIDTH + 16;
	localparam int ROOT_WIDTH    = ROOT_IN_WIDTH / 2;
	localparam int STD_WIDTH     = 16;
	localparam int MEAN_WIDTH    = 16;
	localparam int SCALED_WIDTH  = ROOT_WIDTH + STD_WIDTH;
	localparam int OUT_WIDTH     = 24;

	localparam int LOG_STEPS  = 32;
	localparam int DIV_STEPS  = 32;
	localparam int ROOT_STEPS = ROOT_IN_WIDTH / 2;
	localparam int CNT_WIDTH  = 5;

	// 2*ln(2) in Q1.30
	localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STD_DEVIATION = 4'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEAN_OFFSET   = 4'd1;
	localparam logic [STD_WIDTH-1:0]       STD_RESET         = 16'd4096;

	// power of two so the pointers wrap naturally
	localparam int FIFO_DEPTH     = 2;
	localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic                sign_x;
		logic                sign_y;
		logic [SQ_WIDTH-1:0] xsq;
		logic [SQ_WIDTH-1:0] ysq;
		logic [SQ_WIDTH-1:0] radius;
	} gng_pair_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_LOG,
		ST_LSCALE,
		ST_DSTART,
		ST_DIV,
		ST_MUL,
		ST_ROOT,
		ST_SCALE,
		ST_EMIT
	} gng_state_t;

endpackage

`default_nettype wire

[src/gng_ifs.sv]
// ----------------------------------------------------------------------------
// gng channel interfaces
// uniform pair input, noise sample output and register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface gng_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gng_pkg::UNIFORM_WIDTH-1:0] uniform_x;
	logic signed [gng_pkg::UNIFORM_WIDTH-1:0] uniform_y;

	modport source (output valid, output uniform_x, output uniform_y, input ready);
	modport sink   (input valid, input uniform_x, input uniform_y, output ready);
endinterface

interface gng_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [gng_pkg::OUT_WIDTH-1:0] noise_sample;
	logic                                last_of_pair;

	modport source (output valid, output noise_sample, output last_of_pair, input ready);
	modport sink   (input valid, input noise_sample, input last_of_pair, output ready);
endinterface

interface gng_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [gng_pkg::CFG_INDEX_WIDTH-1:0]   index;
	logic [gng_pkg::CFG_DATA_WIDTH-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/gaussian_noise_generator.sv]
// ----------------------------------------------------------------------------
// gaussian_noise_generator
// polar-method gaussian sample source fed by pairs of uniform samples
// ----------------------------------------------------------------------------
// usage
//   uniform: valid/ready request of two signed Q1.15 samples x and y
//   noise:   valid/ready request of one signed Q8.16 sample; last_of_pair
//            marks the second (y) sample of a pair
//   cfg:     register writes, always ready; index 0 std_deviation (Q4.12),
//            index 1 mean_offset (Q4.12); other indexes are ignored
// pairs with x*x+y*y of zero or above one are dropped with no output
// order: the front registers the squares, the queue holds the pair,
//   and the sequencer takes the log of the radius, then for x and
//   then y the quotient, product, root and scaling
// the single shared sequencer (32-step log, 32-step quotient, 28-step
//   root per sample) takes a new pair only once the last y is emitted
// the front and a 2-deep queue keep taking requests while the back works
// reset clears the queue, the sequencer and the output valid flag;
//   std_deviation returns to 1.0 and mean_offset to 0
// a stalled noise receiver holds the sample and stops the sequencer at
//   its output step; the queue then fills and uniform.ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_noise_generator (
	input  logic       clk,
	input  logic       arst_n,
	gng_in_if.sink     uniform,
	gng_out_if.source  noise,
	gng_cfg_if.sink    cfg
);

	// configuration registers
	logic [gng_pkg::STD_WIDTH-1:0]         std_q;
	logic signed [gng_pkg::MEAN_WIDTH-1:0] mean_q;

	// front to queue, queue to back
	logic               push_valid, push_ready;
	gng_pkg::gng_pair_t push_data;
	logic               pop_valid, pop_ready;
	gng_pkg::gng_pair_t pop_data;

	// writes are taken every cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q  <= gng_pkg::STD_RESET;
			mean_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				gng_pkg::REG_STD_DEVIATION: std_q  <= cfg.data[gng_pkg::STD_WIDTH-1:0];
				gng_pkg::REG_MEAN_OFFSET:   mean_q <= $signed(cfg.data[gng_pkg::MEAN_WIDTH-1:0]);
				default: begin
				end
			endcase
		end
	end

	// squares, radius and disc test
	gng_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.uniform    (uniform),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	gng_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// log, quotient, root and scaling, one pair at a time
	gng_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_data      (pop_data),
		.std_deviation (std_q),
		.mean_offset   (mean_q),
		.noise         (noise)
	);

endmodule

`default_nettype wire

[src/gng_front.sv]
// ----------------------------------------------------------------------------
// gng_front
// squares uniform pairs and drops those of zero radius or outside the unit disc
// ----------------------------------------------------------------------------
`default_nettype none

module gng_front (
	input  logic               clk,
	input  logic               arst_n,
	gng_in_if.sink             uniform,
	output logic               push_valid,
	input  logic               push_ready,
	output gng_pkg::gng_pair_t push_data
);

	logic [gng_pkg::UNIFORM_WIDTH-1:0]   ax, ay;
	logic [2*gng_pkg::UNIFORM_WIDTH-1:0] xsq_full, ysq_full;
	logic [gng_pkg::SQ_WIDTH:0]          radius_sum;
	logic                                reject, advance;

	logic                          valid_s1;
	logic                          sign_x_s1, sign_y_s1;
	logic [gng_pkg::SQ_WIDTH-1:0]  xsq_s1, ysq_s1;

	always_comb begin
		ax = uniform.uniform_x[gng_pkg::UNIFORM_WIDTH-1] ?
			gng_pkg::UNIFORM_WIDTH'(-uniform.uniform_x) : gng_pkg::UNIFORM_WIDTH'(uniform.uniform_x);
		ay = uniform.uniform_y[gng_pkg::UNIFORM_WIDTH-1] ?
			gng_pkg::UNIFORM_WIDTH'(-uniform.uniform_y) : gng_pkg::UNIFORM_WIDTH'(uniform.uniform_y);
		xsq_full = ax * ax;
		ysq_full = ay * ay;
	end

	// radius and disc test on the registered squares
	always_comb begin
		radius_sum = {1'b0, xsq_s1} + {1'b0, ysq_s1};
		reject     = (radius_sum == '0) ||
			(radius_sum > ((gng_pkg::SQ_WIDTH+1)'(1) << (2 * gng_pkg::FRAC_BITS)));
		push_valid = valid_s1 && !reject;
		advance    = !valid_s1 || reject || push_ready;
		push_data.sign_x = sign_x_s1;
		push_data.sign_y = sign_y_s1;
		push_data.xsq    = xsq_s1;
		push_data.ysq    = ysq_s1;
		push_data.radius = radius_sum[gng_pkg::SQ_WIDTH-1:0];
	end

	assign uniform.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= uniform.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && uniform.valid) begin
			sign_x_s1 <= uniform.uniform_x[gng_pkg::UNIFORM_WIDTH-1];
			sign_y_s1 <= uniform.uniform_y[gng_pkg::UNIFORM_WIDTH-1];
			xsq_s1    <= xsq_full[gng_pkg::SQ_WIDTH-1:0];
			ysq_s1    <= ysq_full[gng_pkg::SQ_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

[src/gng_fifo.sv]
// ----------------------------------------------------------------------------
// gng_fifo
// short queue of accepted pairs between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module gng_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  gng_pkg::gng_pair_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output gng_pkg::gng_pair_t pop_data
);

	gng_pkg::gng_pair_t                    entry_q [gng_pkg::FIFO_DEPTH];
	logic [gng_pkg::FIFO_PTR_WIDTH-1:0]    wr_ptr_q, rd_ptr_q;
	logic [gng_pkg::FIFO_CNT_WIDTH-1:0]    count_q;
	logic                                  do_push, do_pop;

	assign push_ready = (count_q != gng_pkg::FIFO_CNT_WIDTH'(gng_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

[src/gng_back.sv]
// ----------------------------------------------------------------------------
// gng_back
// sequencer: log, quotient, product, square root, scaling and output rounding
// ----------------------------------------------------------------------------
`default_nettype none

module gng_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  gng_pkg::gng_pair_t                   pop_data,
	input  logic [gng_pkg::STD_WIDTH-1:0]        std_deviation,
	input  logic signed [gng_pkg::MEAN_WIDTH-1:0] mean_offset,
	gng_out_if.source                            noise
);

	gng_pkg::gng_state_t state_q, state_d;
	gng_pkg::gng_pair_t  pair_q;

	logic [gng_pkg::SQ_WIDTH-1:0]      norm_q, rem_q;
	logic [gng_pkg::SHIFT_WIDTH-1:0]   shift_q;
	logic [31:0]                       mant_q, frac_q;
	logic [gng_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic [gng_pkg::L_WIDTH-1:0]       lval_q;
	logic [gng_pkg::Q_WIDTH-1:0]       quo_q;
	logic [gng_pkg::ROOT_IN_WIDTH-1:0] rad_q, root_q, rbit_q;
	logic [gng_pkg::SCALED_WIDTH-1:0]  scaled_q;
	logic                              sel_q;
	logic                              out_valid_q, out_last_q;
	logic [gng_pkg::OUT_WIDTH-1:0]     out_sample_q;

	logic                                 out_load;
	logic [gng_pkg::SQ_WIDTH+31:0]        norm_ext;
	logic [63:0]                          mant_sq;
	logic [32:0]                          mant_sh;
	logic [gng_pkg::SHIFT_WIDTH-1:0]      nl_hi;
	logic [31:0]                          nl_lo;
	logic [62:0]                          lo_prod;
	logic [gng_pkg::SHIFT_WIDTH+30:0]     hi_prod;
	logic [gng_pkg::L_WIDTH-1:0]          l_next;
	logic [gng_pkg::SQ_WIDTH-1:0]         dividend;
	logic [gng_pkg::SQ_WIDTH:0]           div_shift, div_sub;
	logic                                 div_ge;
	logic [gng_pkg::L_WIDTH-1:0]          mul_hi, p_next;
	logic [63:0]                          mul_lo;
	logic [gng_pkg::ROOT_IN_WIDTH-1:0]    root_t;
	logic                                 root_ge;
	logic                                 sgn;
	logic signed [gng_pkg::SCALED_WIDTH+1:0] mag_s, sum_v, shr_v;
	logic [gng_pkg::OUT_WIDTH-1:0]        sample_d;

	// ---- datapath combinational terms
	always_comb begin
		norm_ext = {norm_q, 32'b0} >> gng_pkg::SQ_WIDTH;
		mant_sq  = mant_q * mant_q;
		mant_sh  = mant_sq[63:31];

		// -log2 r = shift*2^32 - frac
		nl_hi   = shift_q - gng_pkg::SHIFT_WIDTH'(frac_q != 32'd0);
		nl_lo   = 32'd0 - frac_q;
		lo_prod = nl_lo * gng_pkg::TWO_LN2_Q30;
		hi_prod = nl_hi * gng_pkg::TWO_LN2_Q30;
		l_next  = gng_pkg::L_WIDTH'({hi_prod, 2'b00}) + gng_pkg::L_WIDTH'(lo_prod[62:30]);

		dividend  = sel_q ? pair_q.ysq : pair_q.xsq;
		div_shift = {rem_q, 1'b0};
		div_ge    = div_shift >= {1'b0, pair_q.radius};
		div_sub   = div_shift - {1'b0, pair_q.radius};

		mul_hi = lval_q[gng_pkg::L_WIDTH-1:32] * quo_q[31:0];
		mul_lo = lval_q[31:0] * quo_q[31:0];
		p_next = quo_q[32] ? lval_q : mul_hi + gng_pkg::L_WIDTH'(mul_lo[63:32]);

		root_t  = root_q + rbit_q;
		root_ge = rad_q >= root_t;

		// sign, mean, round half up, saturate
		sgn   = sel_q ? pair_q.sign_y : pair_q.sign_x;
		mag_s = $signed({2'b00, scaled_q});
		sum_v = (sgn ? -mag_s : mag_s)
			+ ((gng_pkg::SCALED_WIDTH+2)'(mean_offset) <<< 24)
			+ (gng_pkg::SCALED_WIDTH+2)'(1 << 19);
		shr_v = sum_v >>> 20;
		if (shr_v > (gng_pkg::SCALED_WIDTH+2)'(8388607))
			sample_d = {1'b0, {(gng_pkg::OUT_WIDTH-1){1'b1}}};
		else if (shr_v < -(gng_pkg::SCALED_WIDTH+2)'(8388608))
			sample_d = {1'b1, {(gng_pkg::OUT_WIDTH-1){1'b0}}};
		else
			sample_d = shr_v[gng_pkg::OUT_WIDTH-1:0];
	end

	// ---- outputs of the sequencer
	always_comb begin
		pop_ready = (state_q == gng_pkg::ST_IDLE);
		out_load  = (state_q == gng_pkg::ST_EMIT) && (!out_valid_q || noise.ready);
	end

	// ---- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gng_pkg::ST_IDLE:   if (pop_valid) state_d = gng_pkg::ST_NORM;
			gng_pkg::ST_NORM:   if (norm_q[gng_pkg::SQ_WIDTH-1]) state_d = gng_pkg::ST_LOG;
			gng_pkg::ST_LOG:
				if (cnt_q == gng_pkg::CNT_WIDTH'(gng_pkg::LOG_STEPS - 1))
					state_d = gng_pkg::ST_LSCALE;
			gng_pkg::ST_LSCALE: state_d = gng_pkg::ST_DSTART;
			gng_pkg::ST_DSTART: state_d = gng_pkg::ST_DIV;
			gng_pkg::ST_DIV:
				if (cnt_q == gng_pkg::CNT_WIDTH'(gng_pkg::DIV_STEPS - 1))
					state_d = gng_pkg::ST_MUL;
			gng_pkg::ST_MUL:    state_d = gng_pkg::ST_ROOT;
			gng_pkg::ST_ROOT:
				if (cnt_q == gng_pkg::CNT_WIDTH'(gng_pkg::ROOT_STEPS - 1))
					state_d = gng_pkg::ST_SCALE;
			gng_pkg::ST_SCALE:  state_d = gng_pkg::ST_EMIT;
			gng_pkg::ST_EMIT:
				if (out_load) state_d = sel_q ? gng_pkg::ST_IDLE : gng_pkg::ST_DSTART;
			default:            state_d = gng_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gng_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (noise.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gng_pkg::ST_IDLE: begin
				if (pop_valid) begin
					pair_q  <= pop_data;
					norm_q  <= pop_data.radius;
					shift_q <= '0;
				end
			end
			gng_pkg::ST_NORM: begin
				if (norm_q[gng_pkg::SQ_WIDTH-1]) begin
					mant_q <= norm_ext[31:0];
					frac_q <= '0;
					cnt_q  <= '0;
				end else begin
					norm_q  <= {norm_q[gng_pkg::SQ_WIDTH-2:0], 1'b0};
					shift_q <= shift_q + 1'b1;
				end
			end
			gng_pkg::ST_LOG: begin
				mant_q <= mant_sh[32] ? mant_sh[32:1] : mant_sh[31:0];
				frac_q <= {frac_q[30:0], mant_sh[32]};
				cnt_q  <= cnt_q + 1'b1;
			end
			gng_pkg::ST_LSCALE: begin
				lval_q <= l_next;
				sel_q  <= 1'b0;
			end
			gng_pkg::ST_DSTART: begin
				// a == r gives a quotient of exactly one
				if (dividend == pair_q.radius) begin
					quo_q <= gng_pkg::Q_WIDTH'(1);
					rem_q <= '0;
				end else begin
					quo_q <= '0;
					rem_q <= dividend;
				end
				cnt_q <= '0;
			end
			gng_pkg::ST_DIV: begin
				rem_q <= div_ge ? div_sub[gng_pkg::SQ_WIDTH-1:0] : div_shift[gng_pkg::SQ_WIDTH-1:0];
				quo_q <= {quo_q[gng_pkg::Q_WIDTH-2:0], div_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			gng_pkg::ST_MUL: begin
				rad_q  <= {p_next, 16'b0};
				root_q <= '0;
				rbit_q <= gng_pkg::ROOT_IN_WIDTH'(1) << (gng_pkg::ROOT_IN_WIDTH - 2);
				cnt_q  <= '0;
			end
			gng_pkg::ST_ROOT: begin
				if (root_ge) begin
					rad_q  <= rad_q - root_t;
					root_q <= (root_q >> 1) + rbit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
				cnt_q  <= cnt_q + 1'b1;
			end
			gng_pkg::ST_SCALE: begin
				scaled_q <= root_q[gng_pkg::ROOT_WIDTH-1:0] * std_deviation;
			end
			gng_pkg::ST_EMIT: begin
				if (out_load) begin
					out_sample_q <= sample_d;
					out_last_q   <= sel_q;
					sel_q        <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign noise.valid        = out_valid_q;
	assign noise.noise_sample = out_sample_q;
	assign noise.last_of_pair = out_last_q;

endmodule

`default_nettype wire

[src/gng_checker.sv]
// ----------------------------------------------------------------------------
// gng_checker
// port-level checks on the noise channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_noise_generator_assert.svh"

module gng_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          noise_valid,
	input logic                          noise_ready,
	input logic [gng_pkg::OUT_WIDTH-1:0] noise_sample,
	input logic                          last_of_pair
);

	logic expect_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_last_q <= 1'b0;
		end else if (noise_valid && noise_ready) begin
			expect_last_q <= !expect_last_q;
		end
	end

	`GNG_ASSERT_NEXT(a_stall_hold, noise_valid && !noise_ready, noise_valid && $stable(noise_sample) && $stable(last_of_pair), "noise request changed while stalled")
	`GNG_ASSERT_NOW(a_pair_order, noise_valid, last_of_pair == expect_last_q, "samples not in x then y order")
	`GNG_ASSERT_NOW(a_known_sample, noise_valid, !$isunknown(noise_sample) && !$isunknown(last_of_pair), "unknown bits in a shown noise request")

endmodule

bind gaussian_noise_generator gng_checker u_gng_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.noise_valid  (noise.valid),
	.noise_ready  (noise.ready),
	.noise_sample (noise.noise_sample),
	.last_of_pair (noise.last_of_pair)
);

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// gaussian_noise_generator testbench
// drives pairs of uniform samples through a bit-true fixed-point polar
// method predictor and checks every noise sample against it, across several
// register settings with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	// index that no register answers to
	localparam logic [gng_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 4'd9;
	localparam int IDLE_LIMIT = 5000;
	// time for one pair to pass through the sequencer
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic signed [gng_pkg::OUT_WIDTH-1:0] sample;
		logic                                 last;
	} noise_exp_t;

	// ------------------------------------------------------------------------
	// scoreboard: holds its own copy of the registers and predicts samples
	// ------------------------------------------------------------------------
	class noise_scoreboard;
		logic [gng_pkg::STD_WIDTH-1:0]         std_dev;
		logic signed [gng_pkg::MEAN_WIDTH-1:0] mean;
		noise_exp_t                            pending_samples[$];

		function new();
			std_dev = gng_pkg::STD_RESET;
			mean    = '0;
		endfunction

		function void write_reg(logic [gng_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
			if (idx == gng_pkg::REG_STD_DEVIATION) begin
				std_dev = val;
			end else if (idx == gng_pkg::REG_MEAN_OFFSET) begin
				mean = val;
			end
		endfunction

		// -log2(r) in Q.32, r in units of 2^-30
		function automatic logic [63:0] neg_log2(logic [63:0] r);
			int unsigned msb;
			logic [63:0] m;
			logic [63:0] f;
			msb = 0;
			f = 0;
			while (msb < 63 && (r >> (msb + 1)) != 0) msb++;
			m = (msb >= 31) ? (r >> (msb - 31)) : (r << (31 - msb));
			for (int i = 0; i < 32; i++) begin
				m = (m * m) >> 31;
				f = f << 1;
				if (m >= 64'h1_0000_0000) begin
					f[0] = 1'b1;
					m = m >> 1;
				end
			end
			return ((64'(2 * gng_pkg::FRAC_BITS) - 64'(msb)) << 32) - f;
		endfunction

		function automatic logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res;
			logic [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function automatic logic signed [gng_pkg::OUT_WIDTH-1:0] noise_of(logic neg,
				logic [63:0] usq, logic [63:0] r, logic [63:0] lnr);
			logic [63:0] q;
			logic [63:0] rem;
			logic [63:0] prod;
			logic signed [63:0] v;
			logic signed [63:0] w;
			// usq / r as Q0.32, bit by bit
			q = usq / r;
			rem = usq % r;
			for (int i = 0; i < 32; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= r) begin
					rem = rem - r;
					q[0] = 1'b1;
				end
			end
			if (q >= 64'h1_0000_0000)
				prod = lnr;
			else
				prod = (lnr >> 32) * q + (((lnr & 64'hFFFF_FFFF) * q) >> 32);
			v = $signed(int_sqrt(prod << 16)) * $signed({48'd0, std_dev});
			if (neg) v = -v;
			v = v + ($signed(64'(mean)) <<< 24);
			// floor of (v + half) / 2^20 is round half up
			w = (v + 64'sd524288) >>> 20;
			if (w > 64'sd8388607) w = 64'sd8388607;
			if (w < -64'sd8388608) w = -64'sd8388608;
			return w[gng_pkg::OUT_WIDTH-1:0];
		endfunction

		// an accepted pair; a pair of zero radius or outside the unit circle yields nothing
		function void note_pair(logic signed [15:0] x, logic signed [15:0] y);
			logic [63:0] ax;
			logic [63:0] ay;
			logic [63:0] xsq;
			logic [63:0] ysq;
			logic [63:0] r;
			logic [63:0] nl;
			logic [63:0] lnr;
			noise_exp_t e;
			ax = (x < 0) ? 64'(-$signed(64'(x))) : 64'(x);
			ay = (y < 0) ? 64'(-$signed(64'(y))) : 64'(y);
			xsq = ax * ax;
			ysq = ay * ay;
			r = xsq + ysq;
			if (r == 0 || r > (64'd1 << (2 * gng_pkg::FRAC_BITS))) return;
			nl = neg_log2(r);
			// -2 ln r = -log2 r * 2 ln 2
			lnr = (nl >> 32) * 64'(gng_pkg::TWO_LN2_Q30) * 4
				+ (((nl & 64'hFFFF_FFFF) * 64'(gng_pkg::TWO_LN2_Q30)) >> 30);
			e.sample = noise_of(x < 0, xsq, r, lnr);
			e.last = 1'b0;
			pending_samples.push_back(e);
			e.sample = noise_of(y < 0, ysq, r, lnr);
			e.last = 1'b1;
			pending_samples.push_back(e);
		endfunction

		// empty string when the sample agrees to within one lsb and last_of_pair matches
		function string check_sample(logic signed [gng_pkg::OUT_WIDTH-1:0] s, logic last);
			noise_exp_t e;
			int diff;
			if (pending_samples.size() == 0)
				return $sformatf("unexpected sample %0d last %0b", s, last);
			e = pending_samples.pop_front();
			diff = int'(s) - int'(e.sample);
			if (diff > 1 || diff < -1)
				return $sformatf("sample %0d, predicted %0d", s, e.sample);
			if (last !== e.last)
				return $sformatf("last_of_pair %0b, predicted %0b", last, e.last);
			return "";
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic quiet;       // no idling on either side while set
	int   errors = 0;
	int   idle_cycles;

	gng_in_if  uniform ();
	gng_out_if noise ();
	gng_cfg_if cfg ();

	noise_scoreboard sb = new();

	gaussian_noise_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.uniform(uniform.sink),
		.noise  (noise.source),
		.cfg    (cfg.sink)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// ------------------------------------------------------------------------
	// monitors: requests taken on each channel go to the scoreboard
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		string msg;
		if (arst_n) begin
			if (uniform.valid && uniform.ready)
				sb.note_pair(uniform.uniform_x, uniform.uniform_y);
			if (cfg.valid && cfg.ready)
				sb.write_reg(cfg.index, cfg.data);
			if (noise.valid && noise.ready) begin
				msg = sb.check_sample(noise.noise_sample, noise.last_of_pair);
				if (msg != "") report(msg);
			end
		end
	end

	// noise receiver stalls about one cycle in four unless quiet
	always @(posedge clk) begin
		noise.ready <= quiet || ($urandom_range(99) >= 24);
	end

	// watchdog on cycles in which no request moves
	always @(posedge clk) begin
		if ((uniform.valid && uniform.ready) || (noise.valid && noise.ready)
				|| (cfg.valid && cfg.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("gaussian_noise_generator test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// valid stays high from one pair to the next; lowered only in a gap
	task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y);
		while (!quiet && $urandom_range(99) < 24) begin
			uniform.valid <= 1'b0;
			@(posedge clk);
		end
		uniform.valid     <= 1'b1;
		uniform.uniform_x <= x;
		uniform.uniform_y <= y;
		@(posedge clk);
		while (!uniform.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [gng_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic close_writes();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// every predicted sample in, then room for a dropped pair still in flight
	task automatic settle();
		uniform.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly full-range pairs, which land inside the circle about 3 in 4,
	// with some tiny radii and some pairs hugging the axes at full scale
	task automatic random_pairs(int n);
		int kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(99);
			x = 16'($urandom);
			y = 16'($urandom);
			if (kind < 15) begin
				x = 16'(int'($urandom_range(400)) - 200);
				y = 16'(int'($urandom_range(400)) - 200);
			end else if (kind < 25) begin
				x = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
				y = 16'(int'($urandom_range(64)) - 32);
				if ($urandom_range(1)) {x, y} = {y, x};
			end
			send_pair(x, y);
		end
	endtask

	initial begin
		quiet = 1'b0;
		arst_n <= 1'b0;
		uniform.valid <= 1'b0;
		uniform.uniform_x <= '0;
		uniform.uniform_y <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at reset settings: unit radius, zero radius,
		// corners outside the circle, smallest radii and near-unit radii
		send_pair(16'sh8000, 16'sh0000);
		send_pair(16'sh0000, 16'sh8000);
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh8000, 16'sh0001);
		send_pair(16'sh0001, 16'sh0000);
		send_pair(16'sh0000, 16'shFFFF);
		send_pair(16'shFFFF, 16'shFFFF);
		send_pair(16'sh7FFF, 16'sh0000);
		send_pair(16'sh5A82, 16'sh5A82);
		send_pair(16'shA57E, 16'sh5A82);
		send_pair(16'sh5A83, 16'sh5A83);
		send_pair(16'sh4000, 16'shC000);
		send_pair(16'sh0100, 16'shFF00);
		send_pair(16'sh7FFF, 16'sh0001);
		send_pair(16'sh1234, 16'shEDCC);
		settle();

		// largest gain and mean, pushes outputs into saturation
		write_reg(gng_pkg::REG_STD_DEVIATION, 16'hFFFF);
		write_reg(gng_pkg::REG_MEAN_OFFSET, 16'h7FFF);
		write_reg(REG_UNUSED, 16'h0000);
		close_writes();
		send_pair(16'sh0001, 16'sh0000);
		send_pair(16'sh8000, 16'sh0000);
		send_pair(16'shFFFF, 16'sh0001);
		random_pairs(200);
		settle();

		// zero gain, most negative mean, no idling on either side
		write_reg(gng_pkg::REG_STD_DEVIATION, 16'h0000);
		write_reg(gng_pkg::REG_MEAN_OFFSET, 16'h8000);
		close_writes();
		quiet = 1'b1;
		random_pairs(150);
		settle();
		quiet = 1'b0;

		// random settings
		for (int k = 0; k < 2; k++) begin
			write_reg(gng_pkg::REG_STD_DEVIATION, 16'($urandom));
			write_reg(gng_pkg::REG_MEAN_OFFSET, 16'($urandom));
			write_reg(REG_UNUSED, 16'($urandom));
			close_writes();
			random_pairs(150);
			settle();
		end

		// back to unit gain, small mean
		write_reg(gng_pkg::REG_STD_DEVIATION, gng_pkg::STD_RESET);
		write_reg(gng_pkg::REG_MEAN_OFFSET, 16'h0400);
		close_writes();
		random_pairs(250);
		settle();

		if (errors == 0) begin
			$display("gaussian_noise_generator test passed");
		end else begin
			$display("gaussian_noise_generator test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

[gaussian_noise_generator.f]
+incdir+src
src/gng_pkg.sv
src/gng_ifs.sv
src/gng_front.sv
src/gng_fifo.sv
src/gng_back.sv
src/gaussian_noise_generator.sv
src/gng_checker.sv
tb/sv/tb.sv
